@@ hw/rtl/utf8_stream_analyzer_core_assert.svh @@
// ----------------------------------------------------------------------------
// UTF-8 stream analyzer assertion macros
// Shared concurrent assertion forms for the analyzer RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_ANALYZER_CORE_ASSERT_SVH
`define UTF8_STREAM_ANALYZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usa assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define USA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usa assertion failed in the next cycle");

`endif

@@ hw/rtl/usa_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream analyzer package
// Widths, constants and beat types shared by the analyzer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package usa_pkg;

  localparam int unsigned USA_COUNT_BITS = 16;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned REM_W   = 2;

  localparam logic [LIMIT_W-1:0] PREFIX_RESET = 16'd6;
  localparam logic [POS_W-1:0]   POS_MAX      = 16'hFFFF;
  localparam logic [BYTE_W-1:0]  ASCII_MAX    = 8'd127;

  localparam logic [CP_W-1:0] LAND_LO = 21'h1F400;
  localparam logic [CP_W-1:0] LAND_HI = 21'h1F43F;
  localparam logic [CP_W-1:0] SEA_LO  = 21'h1F980;
  localparam logic [CP_W-1:0] SEA_HI  = 21'h1F9AE;

  localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] byte_length;
    logic [POS_W-1:0] position;
    logic             is_animal;
    logic             in_prefix;
    logic             ascii_so_far;
    logic             string_done;
  } result_t;

endpackage

@@ hw/rtl/usa_stream_if.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream analyzer channel interfaces
// Valid/ready channels for the byte input and the code point output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface usa_byte_if import usa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface usa_point_if import usa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] byte_length;
  logic [POS_W-1:0] position;
  logic             is_animal;
  logic             in_prefix;
  logic             ascii_so_far;
  logic             string_done;

  modport source (
    output valid, output code_point, output byte_length, output position,
    output is_animal, output in_prefix, output ascii_so_far, output string_done,
    input ready
  );
  modport sink (
    input valid, input code_point, input byte_length, input position,
    input is_animal, input in_prefix, input ascii_so_far, input string_done,
    output ready
  );
endinterface

@@ hw/rtl/usa_in_stage.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream analyzer input stage
// Registers each accepted byte beat ahead of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usa_in_stage import usa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  usa_byte_if.sink bytes,
  input  logic     advance,
  output logic     beat_valid,
  output in_beat_t beat
);

  assign bytes.ready = !beat_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      beat_valid <= 1'b1;
    end else if (advance) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      beat.data_byte     <= bytes.data_byte;
      beat.end_of_string <= bytes.end_of_string;
    end
  end

endmodule

@@ hw/rtl/usa_decode.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream analyzer decoder
// Per-string decode state, prefix register and the result of one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usa_decode import usa_pkg::*; #(
  parameter int unsigned COUNT_BITS = USA_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [LIMIT_W-1:0] cfg_write_data,
  input  logic               take,
  input  in_beat_t           beat,
  output logic               emit,
  output result_t            result
);

  `include "utf8_stream_analyzer_core_assert.svh"

  localparam int unsigned WIDE_W = (COUNT_BITS > POS_W) ? COUNT_BITS : POS_W;

  logic [LIMIT_W-1:0]    prefix_limit;
  logic [REM_W-1:0]      bytes_remaining;
  logic [REM_W-1:0]      bytes_remaining_next;
  logic [CP_W-1:0]       accumulator;
  logic [CP_W-1:0]       accumulator_next;
  logic [LEN_W-1:0]      sequence_length;
  logic [LEN_W-1:0]      sequence_length_next;
  logic [COUNT_BITS-1:0] point_count;
  logic [COUNT_BITS-1:0] point_count_next;
  logic                  ascii_flag;
  logic                  ascii_next;
  logic [LEN_W-1:0]      lead;
  logic [CP_W-1:0]       shifted;
  logic [CP_W-1:0]       cp;
  logic [LEN_W-1:0]      blen;
  logic [WIDE_W-1:0]     count_wide;
  logic [BYTE_W-1:0]     b;

  assign b = beat.data_byte;

  always_comb begin
    case (b) inside
      8'b0???????: lead = LEN_ONE;
      8'b110?????: lead = LEN_TWO;
      8'b1110????: lead = LEN_THREE;
      8'b11110???: lead = LEN_FOUR;
      default:     lead = LEN_NONE;
    endcase
  end

  assign shifted = {accumulator[CP_W-7:0], b[5:0]};

  always_comb begin
    ascii_next           = ascii_flag && (b <= ASCII_MAX);
    bytes_remaining_next = bytes_remaining;
    accumulator_next     = accumulator;
    sequence_length_next = sequence_length;
    emit                 = 1'b0;
    cp                   = '0;
    blen                 = LEN_NONE;
    if (bytes_remaining == '0) begin
      case (lead)
        LEN_ONE: begin
          emit = 1'b1;
          cp   = {{(CP_W-BYTE_W){1'b0}}, b};
          blen = LEN_ONE;
        end
        LEN_TWO:   accumulator_next = {{(CP_W-5){1'b0}}, b[4:0]};
        LEN_THREE: accumulator_next = {{(CP_W-4){1'b0}}, b[3:0]};
        LEN_FOUR:  accumulator_next = {{(CP_W-3){1'b0}}, b[2:0]};
        default: ;
      endcase
      if (lead >= LEN_TWO) begin
        bytes_remaining_next = REM_W'(lead - LEN_ONE);
        sequence_length_next = lead;
      end
    end else begin
      bytes_remaining_next = bytes_remaining - REM_W'(1);
      if (bytes_remaining == REM_W'(1)) begin
        emit                 = 1'b1;
        cp                   = shifted;
        blen                 = sequence_length;
        accumulator_next     = '0;
        sequence_length_next = LEN_NONE;
      end else begin
        accumulator_next = shifted;
      end
    end
  end

  assign count_wide = WIDE_W'(point_count);

  always_comb begin
    result.code_point   = cp;
    result.byte_length  = blen;
    result.position     = (count_wide > WIDE_W'(POS_MAX)) ? POS_MAX
                                                          : count_wide[POS_W-1:0];
    result.is_animal    = (cp inside {[LAND_LO:LAND_HI], [SEA_LO:SEA_HI]});
    result.in_prefix    = count_wide < WIDE_W'(prefix_limit);
    result.ascii_so_far = ascii_next;
    result.string_done  = beat.end_of_string;
  end

  always_comb begin
    point_count_next = point_count;
    if (emit && (point_count != '1)) begin
      point_count_next = point_count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_limit <= PREFIX_RESET;
    end else if (cfg_write_en) begin
      prefix_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      accumulator     <= '0;
      sequence_length <= LEN_NONE;
      point_count     <= '0;
      ascii_flag      <= 1'b1;
    end else if (take) begin
      if (beat.end_of_string) begin
        bytes_remaining <= '0;
        accumulator     <= '0;
        sequence_length <= LEN_NONE;
        point_count     <= '0;
        ascii_flag      <= 1'b1;
      end else begin
        bytes_remaining <= bytes_remaining_next;
        accumulator     <= accumulator_next;
        sequence_length <= sequence_length_next;
        point_count     <= point_count_next;
        ascii_flag      <= ascii_next;
      end
    end
  end

  `USA_ASSERT_NEXT(a_eos_clears, clk, rst, take && beat.end_of_string, (bytes_remaining == '0) && (point_count == '0) && ascii_flag)
  `USA_ASSERT_SAME(a_emit_len, clk, rst, emit, (blen != LEN_NONE) && (blen <= LEN_FOUR))
  `USA_ASSERT_SAME(a_single_lead, clk, rst, emit && (blen == LEN_ONE), bytes_remaining == '0)

endmodule

@@ hw/rtl/usa_out_stage.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream analyzer output stage
// Holds one finished code point beat until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usa_out_stage import usa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        free,
  usa_point_if.source points
);

  result_t held;

  assign free = !points.valid || points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      points.valid <= 1'b0;
    end else if (load) begin
      points.valid <= 1'b1;
    end else if (points.ready) begin
      points.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign points.code_point   = held.code_point;
  assign points.byte_length  = held.byte_length;
  assign points.position     = held.position;
  assign points.is_animal    = held.is_animal;
  assign points.in_prefix    = held.in_prefix;
  assign points.ascii_so_far = held.ascii_so_far;
  assign points.string_done  = held.string_done;

endmodule

@@ hw/rtl/utf8_stream_analyzer_core.sv @@
// A code point's final byte is accepted into the input register, decoded and
// loaded into the output register. Throughput: one byte per cycle without
// back-pressure, set by the single decode stage between the two registers.
// Reset: synchronous and active high; it empties both registers, clears the
// per-string decode state and sets prefix_limit to 6.
// ----------------------------------------------------------------------------
// UTF-8 stream analyzer core
// Decodes a UTF-8 byte stream into code points with position and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_analyzer_core import usa_pkg::*; #(
  parameter int unsigned COUNT_BITS = USA_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [LIMIT_W-1:0] cfg_write_data,
  usa_byte_if.sink           bytes,
  usa_point_if.source        points
);

  logic     beat_valid;
  in_beat_t beat;
  logic     advance;
  logic     out_free;
  logic     emit;
  result_t  result;

  assign advance = beat_valid && out_free;

  usa_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  usa_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .take           (advance),
    .beat           (beat),
    .emit           (emit),
    .result         (result)
  );

  usa_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && emit),
    .result (result),
    .free   (out_free),
    .points (points)
  );

endmodule
